/* src/json_byte_tokenizer_unit_macros.svh */
// Assertion macros shared by the tokenizer RTL.
// Each macro expands to a labelled concurrent assertion unless SYNTH is defined.
`ifndef JSON_BYTE_TOKENIZER_UNIT_MACROS_SVH
`define JSON_BYTE_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTH

// The condition holds at every clock edge out of reset.
`define JBT_ASSERT_ALWAYS(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (cond)) \
        else $error("tokenizer assertion failed");

// The consequence holds in the same cycle as the antecedent.
`define JBT_ASSERT_IMPLY(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// The consequence holds in the cycle after the antecedent.
`define JBT_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`else

`define JBT_ASSERT_ALWAYS(label, ck, rn, cond)
`define JBT_ASSERT_IMPLY(label, ck, rn, ante, cons)
`define JBT_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

/* src/jbt_pkg.sv */
`default_nettype none

package jbt_pkg;

    // Default widths of the position and length fields.
    localparam int POS_WIDTH_DEF = 32;
    localparam int LEN_WIDTH_DEF = 16;

    // Token kinds carried by each result word.
    typedef enum logic [3:0] {
        K_OBJ_BEGIN   = 4'd0,
        K_OBJ_END     = 4'd1,
        K_ARR_BEGIN   = 4'd2,
        K_ARR_END     = 4'd3,
        K_COMMA       = 4'd4,
        K_COLON       = 4'd5,
        K_FALSE       = 4'd6,
        K_TRUE        = 4'd7,
        K_NULL        = 4'd8,
        K_INTEGER     = 4'd9,
        K_FLOAT       = 4'd10,
        K_STRING      = 4'd11,
        K_STRING_BYTE = 4'd12,
        K_EOF         = 4'd13,
        K_ERROR       = 4'd14
    } kind_t;

    // Keyword selectors.
    localparam logic [1:0] KW_FALSE = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // UTF-8 encoding limits and prefixes.
    localparam logic [15:0] UTF8_MAX_ONE = 16'h007F;
    localparam logic [15:0] UTF8_MAX_TWO = 16'h07FF;
    localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;

    // Length of each keyword in bytes.
    function automatic logic [2:0] kw_length(input logic [1:0] sel);
        logic [2:0] len;
        unique case (sel)
            KW_FALSE: len = 3'd5;
            KW_TRUE:  len = 3'd4;
            default:  len = 3'd4;
        endcase
        return len;
    endfunction

    // Character of a keyword at a given index.
    function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] idx);
        logic [7:0] ch;
        unique case ({sel, idx})
            {KW_FALSE, 3'd0}: ch = "f";
            {KW_FALSE, 3'd1}: ch = "a";
            {KW_FALSE, 3'd2}: ch = "l";
            {KW_FALSE, 3'd3}: ch = "s";
            {KW_FALSE, 3'd4}: ch = "e";
            {KW_TRUE,  3'd0}: ch = "t";
            {KW_TRUE,  3'd1}: ch = "r";
            {KW_TRUE,  3'd2}: ch = "u";
            {KW_TRUE,  3'd3}: ch = "e";
            {KW_NULL,  3'd0}: ch = "n";
            {KW_NULL,  3'd1}: ch = "u";
            {KW_NULL,  3'd2}: ch = "l";
            {KW_NULL,  3'd3}: ch = "l";
            default:          ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Token kind reported for a finished keyword.
    function automatic kind_t kw_kind(input logic [1:0] sel);
        kind_t k;
        unique case (sel)
            KW_FALSE: k = K_FALSE;
            KW_TRUE:  k = K_TRUE;
            default:  k = K_NULL;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* src/json_byte_tokenizer_unit.sv */
// JSON byte tokenizer. Takes one text byte (or an end marker) per input word and
// returns token words: punctuation, keywords, integer and float numbers, strings
// and their decoded content bytes, eof and error. The lexer state is updated in
// the cycle a byte is accepted and its results are written into a four-entry
// output queue. The output side delivers one result word per cycle while
// result_stall is low; a byte that causes one result or none is then taken
// every cycle, while a byte that causes two or three (a number or keyword
// closed by punctuation, a \u escape, the end marker) holds the input stalled
// while the queue drains. The input stalls whenever the queue holds more than
// one word.

`default_nettype none

`include "json_byte_tokenizer_unit_macros.svh"

module json_byte_tokenizer_unit #(
    parameter int POS_WIDTH = jbt_pkg::POS_WIDTH_DEF,
    parameter int LEN_WIDTH = jbt_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic [7:0]            text_byte,
    input  wire logic                  end_mark,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output jbt_pkg::kind_t             kind,
    output logic [7:0]                 content_byte,
    output logic [POS_WIDTH-1:0]       start_pos,
    output logic [LEN_WIDTH-1:0]       token_len,
    output logic                       last
);

    import jbt_pkg::*;

    localparam int Q_DEPTH = 4;
    localparam int MAX_RES = 3;
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    // Lexer modes.
    typedef enum logic [3:0] {
        M_IDLE,
        M_KW,
        M_KW_END,
        M_NUM_SIGN,
        M_NUM_INT,
        M_FRAC0,
        M_FRAC,
        M_EXP0,
        M_EXPS,
        M_EXP,
        M_STR,
        M_STR_ESC,
        M_STR_HEX
    } mode_t;

    // One result word.
    typedef struct packed {
        kind_t                kind;
        logic [7:0]           content;
        logic [POS_WIDTH-1:0] start;
        logic [LEN_WIDTH-1:0] len;
        logic                 last;
    } res_t;

    // Lexer state.
    mode_t                mode_reg,        mode_next;
    logic [1:0]           kw_sel_reg,      kw_sel_next;
    logic [2:0]           kw_idx_reg,      kw_idx_next;
    logic                 is_float_reg,    is_float_next;
    logic [15:0]          hex_accum_reg,   hex_accum_next;
    logic [1:0]           hex_count_reg,   hex_count_next;
    logic [POS_WIDTH-1:0] byte_pos_reg,    byte_pos_next;
    logic [POS_WIDTH-1:0] token_begin_reg, token_begin_next;
    logic [LEN_WIDTH-1:0] length_reg,      length_next;
    logic                 error_reg,       error_next;

    // Output queue.
    res_t                 q_reg [Q_DEPTH];
    res_t                 q_next [Q_DEPTH];
    logic [CNT_W-1:0]     cnt_reg,         cnt_next;

    // Results of the current byte.
    res_t                 res [MAX_RES];
    logic [1:0]           res_n;

    logic                 accept;
    logic                 pop;

    // Byte classes.
    logic                 digit_byte;
    logic                 is_letter;
    logic                 is_hex;
    logic [3:0]           hex_val;
    logic [15:0]          hex_new;

    // Outcome of lexing the byte between tokens.
    logic                 idle_emit;
    kind_t                idle_kind;
    logic                 idle_fail;
    mode_t                idle_mode;
    logic                 idle_start;
    logic                 idle_len_one;
    logic                 idle_kw;
    logic [1:0]           idle_sel;

    logic [1:0]           kw_s;
    logic [POS_WIDTH-1:0] pos_inc;
    logic [LEN_WIDTH-1:0] len_inc;

    // Handshakes.
    assign accept       = item_valid && !item_stall;
    assign pop          = (cnt_reg != '0) && !result_stall;
    assign item_stall   = cnt_reg > CNT_W'(Q_DEPTH - MAX_RES);
    assign result_valid = cnt_reg != '0;

    assign kind         = q_reg[0].kind;
    assign content_byte = q_reg[0].content;
    assign start_pos    = q_reg[0].start;
    assign token_len    = q_reg[0].len;
    assign last         = q_reg[0].last;

    // Byte classes and saturating counters.
    assign digit_byte = (text_byte >= "0") && (text_byte <= "9");
    assign is_letter  = ((text_byte >= "A") && (text_byte <= "Z"))
                     || ((text_byte >= "a") && (text_byte <= "z"));
    assign is_hex     = digit_byte || ((text_byte >= "A") && (text_byte <= "F"));
    assign hex_val    = digit_byte ? text_byte[3:0] : (text_byte[3:0] + 4'd9);
    assign hex_new    = {hex_accum_reg[11:0], hex_val};
    assign kw_s       = (kw_sel_reg > KW_NULL) ? KW_NULL : kw_sel_reg;
    assign pos_inc    = (&byte_pos_reg) ? byte_pos_reg : byte_pos_reg + 1'b1;
    assign len_inc    = (&length_reg) ? length_reg : length_reg + 1'b1;

    // Decode of a byte that arrives between tokens.
    always_comb
    begin
        idle_emit    = 1'b0;
        idle_kind    = K_ERROR;
        idle_fail    = 1'b0;
        idle_mode    = M_IDLE;
        idle_start   = 1'b0;
        idle_len_one = 1'b0;
        idle_kw      = 1'b0;
        idle_sel     = KW_FALSE;
        unique case (text_byte) inside
            8'h09, 8'h0A, 8'h0B, 8'h0D, " ":
            begin
                idle_mode = M_IDLE;
            end
            "{":
            begin
                idle_emit = 1'b1;
                idle_kind = K_OBJ_BEGIN;
            end
            "}":
            begin
                idle_emit = 1'b1;
                idle_kind = K_OBJ_END;
            end
            "[":
            begin
                idle_emit = 1'b1;
                idle_kind = K_ARR_BEGIN;
            end
            "]":
            begin
                idle_emit = 1'b1;
                idle_kind = K_ARR_END;
            end
            ",":
            begin
                idle_emit = 1'b1;
                idle_kind = K_COMMA;
            end
            ":":
            begin
                idle_emit = 1'b1;
                idle_kind = K_COLON;
            end
            "f", "t", "n":
            begin
                idle_mode  = M_KW;
                idle_start = 1'b1;
                idle_kw    = 1'b1;
                idle_sel   = (text_byte == "f") ? KW_FALSE
                           : (text_byte == "t") ? KW_TRUE : KW_NULL;
            end
            "-":
            begin
                idle_mode    = M_NUM_SIGN;
                idle_start   = 1'b1;
                idle_len_one = 1'b1;
            end
            "\"":
            begin
                idle_mode  = M_STR;
                idle_start = 1'b1;
            end
            ["0":"9"]:
            begin
                idle_mode    = M_NUM_INT;
                idle_start   = 1'b1;
                idle_len_one = 1'b1;
            end
            default:
            begin
                idle_emit = 1'b1;
                idle_kind = K_ERROR;
                idle_fail = 1'b1;
            end
        endcase
    end

    // Lexer step: next state and up to three results for the current word.
    always_comb
    begin
        mode_next        = mode_reg;
        kw_sel_next      = kw_sel_reg;
        kw_idx_next      = kw_idx_reg;
        is_float_next    = is_float_reg;
        hex_accum_next   = hex_accum_reg;
        hex_count_next   = hex_count_reg;
        byte_pos_next    = byte_pos_reg;
        token_begin_next = token_begin_reg;
        length_next      = length_reg;
        error_next       = error_reg;
        res_n            = 2'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            res[i] = '{kind: K_ERROR, content: 8'h00, start: '0, len: '0, last: 1'b0};
        end

        if (end_mark)
        begin
            // Flush a finished number or keyword, then report eof and reset.
            if (!error_reg)
            begin
                if (mode_reg == M_KW_END)
                begin
                    res[res_n].kind  = kw_kind(kw_s);
                    res[res_n].start = token_begin_reg;
                    res_n = res_n + 2'd1;
                end
                else if (mode_reg == M_NUM_INT || mode_reg == M_FRAC || mode_reg == M_EXP)
                begin
                    res[res_n].kind  = is_float_reg ? K_FLOAT : K_INTEGER;
                    res[res_n].start = token_begin_reg;
                    res[res_n].len   = length_reg;
                    res_n = res_n + 2'd1;
                end
            end
            res[res_n].kind  = K_EOF;
            res[res_n].start = byte_pos_reg;
            res_n = res_n + 2'd1;

            mode_next        = M_IDLE;
            kw_sel_next      = KW_FALSE;
            kw_idx_next      = 3'd0;
            is_float_next    = 1'b0;
            hex_accum_next   = 16'h0000;
            hex_count_next   = 2'd0;
            byte_pos_next    = '0;
            token_begin_next = '0;
            length_next      = '0;
            error_next       = 1'b0;
        end
        else
        begin
            byte_pos_next = pos_inc;
            if (!error_reg)
            begin
                // Handle the byte in the current mode; terminators fall through
                // to the between-token decode below.
                logic do_idle;
                logic do_fail;
                do_idle = 1'b0;
                do_fail = 1'b0;
                unique case (mode_reg)
                    M_IDLE:
                    begin
                        do_idle = 1'b1;
                    end
                    M_KW:
                    begin
                        if ((kw_idx_reg < kw_length(kw_s)) && (text_byte == kw_char(kw_s, kw_idx_reg)))
                        begin
                            kw_idx_next = kw_idx_reg + 3'd1;
                            if (kw_idx_next >= kw_length(kw_s))
                            begin
                                mode_next = M_KW_END;
                            end
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    M_KW_END:
                    begin
                        if (is_letter)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            res[res_n].kind  = kw_kind(kw_s);
                            res[res_n].start = token_begin_reg;
                            res_n   = res_n + 2'd1;
                            do_idle = 1'b1;
                        end
                    end
                    M_NUM_SIGN, M_FRAC0, M_EXPS:
                    begin
                        if (digit_byte)
                        begin
                            length_next = len_inc;
                            mode_next   = (mode_reg == M_NUM_SIGN) ? M_NUM_INT
                                        : (mode_reg == M_FRAC0) ? M_FRAC : M_EXP;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    M_NUM_INT, M_FRAC, M_EXP:
                    begin
                        if (digit_byte)
                        begin
                            length_next = len_inc;
                        end
                        else if (text_byte == "." && mode_reg == M_NUM_INT)
                        begin
                            length_next   = len_inc;
                            is_float_next = 1'b1;
                            mode_next     = M_FRAC0;
                        end
                        else if ((text_byte == "e" || text_byte == "E") && mode_reg != M_EXP)
                        begin
                            length_next   = len_inc;
                            is_float_next = 1'b1;
                            mode_next     = M_EXP0;
                        end
                        else
                        begin
                            res[res_n].kind  = is_float_reg ? K_FLOAT : K_INTEGER;
                            res[res_n].start = token_begin_reg;
                            res[res_n].len   = length_reg;
                            res_n   = res_n + 2'd1;
                            do_idle = 1'b1;
                        end
                    end
                    M_EXP0:
                    begin
                        if (text_byte == "+" || text_byte == "-")
                        begin
                            length_next = len_inc;
                            mode_next   = M_EXPS;
                        end
                        else if (digit_byte)
                        begin
                            length_next = len_inc;
                            mode_next   = M_EXP;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    M_STR:
                    begin
                        if (text_byte == "\"")
                        begin
                            res[res_n].kind  = K_STRING;
                            res[res_n].start = token_begin_reg;
                            res[res_n].len   = length_reg;
                            res_n     = res_n + 2'd1;
                            mode_next = M_IDLE;
                        end
                        else if (text_byte == "\\")
                        begin
                            length_next = len_inc;
                            mode_next   = M_STR_ESC;
                        end
                        else
                        begin
                            length_next = len_inc;
                            res[res_n].kind    = K_STRING_BYTE;
                            res[res_n].content = text_byte;
                            res[res_n].start   = token_begin_reg;
                            res_n = res_n + 2'd1;
                        end
                    end
                    M_STR_ESC:
                    begin
                        logic [7:0] esc;
                        logic       esc_ok;
                        esc         = 8'h00;
                        esc_ok      = 1'b1;
                        length_next = len_inc;
                        case (text_byte)
                            "\"":    esc = 8'h22;
                            "\\":    esc = 8'h5C;
                            "/":     esc = 8'h2F;
                            "b":     esc = 8'h08;
                            "f":     esc = 8'h0C;
                            "n":     esc = 8'h0A;
                            "r":     esc = 8'h0D;
                            "t":     esc = 8'h09;
                            default: esc_ok = 1'b0;
                        endcase
                        if (text_byte == "u")
                        begin
                            hex_accum_next = 16'h0000;
                            hex_count_next = 2'd0;
                            mode_next      = M_STR_HEX;
                        end
                        else if (esc_ok)
                        begin
                            res[res_n].kind    = K_STRING_BYTE;
                            res[res_n].content = esc;
                            res[res_n].start   = token_begin_reg;
                            res_n     = res_n + 2'd1;
                            mode_next = M_STR;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    M_STR_HEX:
                    begin
                        length_next = len_inc;
                        if (!is_hex)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            hex_accum_next = hex_new;
                            if (hex_count_reg == 2'd3)
                            begin
                                // Encode the code unit as one to three UTF-8 bytes.
                                mode_next = M_STR;
                                res[0].kind  = K_STRING_BYTE;
                                res[0].start = token_begin_reg;
                                if (hex_new <= UTF8_MAX_ONE)
                                begin
                                    res[0].content = {1'b0, hex_new[6:0]};
                                    res_n = 2'd1;
                                end
                                else if (hex_new <= UTF8_MAX_TWO)
                                begin
                                    res[0].content = UTF8_LEAD2 | {3'b000, hex_new[10:6]};
                                    res[1].kind    = K_STRING_BYTE;
                                    res[1].start   = token_begin_reg;
                                    res[1].content = UTF8_CONT | {2'b00, hex_new[5:0]};
                                    res_n = 2'd2;
                                end
                                else
                                begin
                                    res[0].content = UTF8_LEAD3 | {4'b0000, hex_new[15:12]};
                                    res[1].kind    = K_STRING_BYTE;
                                    res[1].start   = token_begin_reg;
                                    res[1].content = UTF8_CONT | {2'b00, hex_new[11:6]};
                                    res[2].kind    = K_STRING_BYTE;
                                    res[2].start   = token_begin_reg;
                                    res[2].content = UTF8_CONT | {2'b00, hex_new[5:0]};
                                    res_n = 2'd3;
                                end
                            end
                            else
                            begin
                                hex_count_next = hex_count_reg + 2'd1;
                            end
                        end
                    end
                    default:
                    begin
                        do_idle = 1'b1;
                    end
                endcase

                // Failure in the current token.
                if (do_fail)
                begin
                    res[res_n].kind  = K_ERROR;
                    res[res_n].start = byte_pos_reg;
                    res_n      = res_n + 2'd1;
                    error_next = 1'b1;
                    mode_next  = M_IDLE;
                end

                // Byte lexed as the start of a new token.
                if (do_idle)
                begin
                    mode_next = idle_mode;
                    if (idle_emit)
                    begin
                        res[res_n].kind  = idle_kind;
                        res[res_n].start = byte_pos_reg;
                        res_n = res_n + 2'd1;
                    end
                    if (idle_fail)
                    begin
                        error_next = 1'b1;
                    end
                    if (idle_start)
                    begin
                        token_begin_next = byte_pos_reg;
                        length_next      = idle_len_one ? LEN_WIDTH'(1) : '0;
                        is_float_next    = 1'b0;
                    end
                    if (idle_kw)
                    begin
                        kw_sel_next = idle_sel;
                        kw_idx_next = 3'd1;
                    end
                end
            end
        end
    end

    // Output queue: shift out on a pop, append new results behind what remains.
    always_comb
    begin
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] idx;
        base = cnt_reg - CNT_W'(pop);
        for (int i = 0; i < Q_DEPTH - 1; i++)
        begin
            q_next[i] = pop ? q_reg[i + 1] : q_reg[i];
        end
        q_next[Q_DEPTH-1] = q_reg[Q_DEPTH-1];
        for (int i = 0; i < Q_DEPTH; i++)
        begin
            idx = CNT_W'(i) - base;
            if (accept && (CNT_W'(i) >= base) && (idx < CNT_W'(res_n)))
            begin
                q_next[i]      = res[idx[1:0]];
                q_next[i].last = idx[1:0] == (res_n - 2'd1);
            end
        end
        cnt_next = base + (accept ? CNT_W'(res_n) : '0);
    end

    // State and queue registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= M_IDLE;
            kw_sel_reg      <= KW_FALSE;
            kw_idx_reg      <= 3'd0;
            is_float_reg    <= 1'b0;
            hex_accum_reg   <= 16'h0000;
            hex_count_reg   <= 2'd0;
            byte_pos_reg    <= '0;
            token_begin_reg <= '0;
            length_reg      <= '0;
            error_reg       <= 1'b0;
            cnt_reg         <= '0;
            for (int i = 0; i < Q_DEPTH; i++)
            begin
                q_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                mode_reg        <= mode_next;
                kw_sel_reg      <= kw_sel_next;
                kw_idx_reg      <= kw_idx_next;
                is_float_reg    <= is_float_next;
                hex_accum_reg   <= hex_accum_next;
                hex_count_reg   <= hex_count_next;
                byte_pos_reg    <= byte_pos_next;
                token_begin_reg <= token_begin_next;
                length_reg      <= length_next;
                error_reg       <= error_next;
            end
            cnt_reg <= cnt_next;
            for (int i = 0; i < Q_DEPTH; i++)
            begin
                q_reg[i] <= q_next[i];
            end
        end
    end

    // The queue never holds more words than it has entries.
    `JBT_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, cnt_reg <= CNT_W'(Q_DEPTH))

    // After an error the lexer waits between tokens until the end marker.
    `JBT_ASSERT_IMPLY(a_error_idle, clk, rst_n, error_reg, mode_reg == M_IDLE)

    // An accepted end marker returns the lexer and the position to reset values.
    `JBT_ASSERT_NEXT(a_end_reset, clk, rst_n, accept && end_mark, (mode_reg == M_IDLE) && (byte_pos_reg == '0) && !error_reg)

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import jbt_pkg::*;

    // Modes of the lexer as the prediction tracks them.
    typedef enum logic [3:0] {
        LEX_IDLE,
        LEX_KEYWORD,
        LEX_KEYWORD_END,
        LEX_MINUS,
        LEX_INT,
        LEX_FRAC_FIRST,
        LEX_FRAC,
        LEX_EXP_MARK,
        LEX_EXP_SIGN,
        LEX_EXP,
        LEX_STR,
        LEX_STR_ESC,
        LEX_STR_HEX
    } lex_mode_t;

    // One token word as the block should return it.
    typedef struct {
        kind_t       kind;
        logic [7:0]  content;
        logic [31:0] pos;
        logic [15:0] len;
        logic        last;
    } token_rec_t;

    localparam int QUIET_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [7:0]  text_byte = 8'h00;
    logic        end_mark = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    kind_t       kind;
    logic [7:0]  content_byte;
    logic [31:0] start_pos;
    logic [15:0] token_len;
    logic        last;

    // Tokens predicted but not yet returned, oldest first.
    token_rec_t  pending_tokens[$];
    token_rec_t  step_tokens[$];
    logic [7:0]  doc_bytes[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int stall_hold = 0;

    string keyword_spelling[3] = '{"false", "true", "null"};
    string punct_set = "{}[],:";
    string escape_set = "\"\\/bfnrt";
    string space_set = "\t\n\013\015 ";
    string sep_set = " ,:\n";

    // Shadow state of the lexer.
    lex_mode_t   lex_mode = LEX_IDLE;
    logic [1:0]  kw_sel = 2'd0;
    logic [2:0]  kw_idx = 3'd0;
    logic        num_is_float = 1'b0;
    logic [15:0] hex_acc = 16'h0000;
    logic [1:0]  hex_cnt = 2'd0;
    logic [31:0] text_pos = 32'd0;
    logic [31:0] tok_start = 32'd0;
    logic [15:0] tok_len_cnt = 16'd0;
    logic        err_latched = 1'b0;

    json_byte_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .text_byte    (text_byte),
        .end_mark     (end_mark),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .content_byte (content_byte),
        .start_pos    (start_pos),
        .token_len    (token_len),
        .last         (last)
    );

    // Clock generation.
    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bit digit_char(input logic [7:0] ch);
        return ch >= 8'h30 && ch <= 8'h39;
    endfunction

    function automatic bit is_letter_char(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'h30 + 8'($urandom_range(9, 0));
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
    endfunction

    // Records one token of the current word; the flag for the final one is set later.
    task automatic note_token(input kind_t k, input logic [7:0] c, input logic [31:0] p,
                              input logic [15:0] l);
        token_rec_t rec;
        rec.kind = k;
        rec.content = c;
        rec.pos = p;
        rec.len = l;
        rec.last = 1'b0;
        step_tokens.push_back(rec);
    endtask

    task automatic bump_length();
        if (tok_len_cnt != 16'hFFFF)
            tok_len_cnt = tok_len_cnt + 16'd1;
    endtask

    task automatic raise_error(input logic [31:0] p);
        note_token(K_ERROR, 8'h00, p, 16'd0);
        err_latched = 1'b1;
        lex_mode = LEX_IDLE;
    endtask

    task automatic close_number();
        note_token(num_is_float ? K_FLOAT : K_INTEGER, 8'h00, tok_start, tok_len_cnt);
        lex_mode = LEX_IDLE;
    endtask

    task automatic close_keyword();
        note_token(kind_t'(4'(K_FALSE) + 4'(kw_sel)), 8'h00, tok_start, 16'd0);
        lex_mode = LEX_IDLE;
    endtask

    task automatic begin_token(input lex_mode_t m, input logic [31:0] p);
        lex_mode = m;
        tok_start = p;
        tok_len_cnt = 16'd0;
        num_is_float = 1'b0;
    endtask

    // A byte seen between tokens.
    task automatic lex_between_tokens(input logic [7:0] ch, input logic [31:0] p);
        case (ch)
            8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h20: ;
            "{": note_token(K_OBJ_BEGIN, 8'h00, p, 16'd0);
            "}": note_token(K_OBJ_END, 8'h00, p, 16'd0);
            "[": note_token(K_ARR_BEGIN, 8'h00, p, 16'd0);
            "]": note_token(K_ARR_END, 8'h00, p, 16'd0);
            ",": note_token(K_COMMA, 8'h00, p, 16'd0);
            ":": note_token(K_COLON, 8'h00, p, 16'd0);
            "f", "t", "n":
            begin
                begin_token(LEX_KEYWORD, p);
                kw_sel = (ch == "f") ? KW_FALSE : (ch == "t") ? KW_TRUE : KW_NULL;
                kw_idx = 3'd1;
            end
            "-":
            begin
                begin_token(LEX_MINUS, p);
                bump_length();
            end
            8'h22: begin_token(LEX_STR, p);
            default:
            begin
                if (digit_char(ch))
                begin
                    begin_token(LEX_INT, p);
                    bump_length();
                end
                else
                    raise_error(p);
            end
        endcase
    endtask

    // A code point from a \u escape, as one to three UTF-8 bytes.
    task automatic put_utf8(input logic [15:0] v);
        if (v <= UTF8_MAX_ONE)
            note_token(K_STRING_BYTE, {1'b0, v[6:0]}, tok_start, 16'd0);
        else if (v <= UTF8_MAX_TWO)
        begin
            note_token(K_STRING_BYTE, UTF8_LEAD2 | {3'b000, v[10:6]}, tok_start, 16'd0);
            note_token(K_STRING_BYTE, UTF8_CONT | {2'b00, v[5:0]}, tok_start, 16'd0);
        end
        else
        begin
            note_token(K_STRING_BYTE, UTF8_LEAD3 | {4'h0, v[15:12]}, tok_start, 16'd0);
            note_token(K_STRING_BYTE, UTF8_CONT | {2'b00, v[11:6]}, tok_start, 16'd0);
            note_token(K_STRING_BYTE, UTF8_CONT | {2'b00, v[5:0]}, tok_start, 16'd0);
        end
    endtask

    // One text byte through the lexer, before any error.
    task automatic lex_text_byte(input logic [7:0] ch, input logic [31:0] p);
        string      spelling;
        logic [7:0] decoded;
        logic [3:0] nibble;
        bit         known;
        spelling = keyword_spelling[kw_sel];
        case (lex_mode)
            LEX_KEYWORD:
            begin
                if (kw_idx < spelling.len() && ch == spelling[kw_idx])
                begin
                    kw_idx = kw_idx + 3'd1;
                    if (kw_idx >= spelling.len())
                        lex_mode = LEX_KEYWORD_END;
                end
                else
                    raise_error(p);
            end
            LEX_KEYWORD_END:
            begin
                if (is_letter_char(ch))
                    raise_error(p);
                else
                begin
                    close_keyword();
                    lex_between_tokens(ch, p);
                end
            end
            LEX_MINUS:
            begin
                if (digit_char(ch))
                begin
                    bump_length();
                    lex_mode = LEX_INT;
                end
                else
                    raise_error(p);
            end
            LEX_INT, LEX_FRAC:
            begin
                if (digit_char(ch))
                    bump_length();
                else if (ch == "." && lex_mode == LEX_INT)
                begin
                    bump_length();
                    num_is_float = 1'b1;
                    lex_mode = LEX_FRAC_FIRST;
                end
                else if (ch == "e" || ch == "E")
                begin
                    bump_length();
                    num_is_float = 1'b1;
                    lex_mode = LEX_EXP_MARK;
                end
                else
                begin
                    close_number();
                    lex_between_tokens(ch, p);
                end
            end
            LEX_FRAC_FIRST:
            begin
                if (digit_char(ch))
                begin
                    bump_length();
                    lex_mode = LEX_FRAC;
                end
                else
                    raise_error(p);
            end
            LEX_EXP_MARK:
            begin
                if (ch == "+" || ch == "-")
                begin
                    bump_length();
                    lex_mode = LEX_EXP_SIGN;
                end
                else if (digit_char(ch))
                begin
                    bump_length();
                    lex_mode = LEX_EXP;
                end
                else
                    raise_error(p);
            end
            LEX_EXP_SIGN:
            begin
                if (digit_char(ch))
                begin
                    bump_length();
                    lex_mode = LEX_EXP;
                end
                else
                    raise_error(p);
            end
            LEX_EXP:
            begin
                if (digit_char(ch))
                    bump_length();
                else
                begin
                    close_number();
                    lex_between_tokens(ch, p);
                end
            end
            LEX_STR:
            begin
                if (ch == 8'h22)
                begin
                    note_token(K_STRING, 8'h00, tok_start, tok_len_cnt);
                    lex_mode = LEX_IDLE;
                end
                else if (ch == 8'h5C)
                begin
                    bump_length();
                    lex_mode = LEX_STR_ESC;
                end
                else
                begin
                    bump_length();
                    note_token(K_STRING_BYTE, ch, tok_start, 16'd0);
                end
            end
            LEX_STR_ESC:
            begin
                bump_length();
                if (ch == "u")
                begin
                    hex_acc = 16'h0000;
                    hex_cnt = 2'd0;
                    lex_mode = LEX_STR_HEX;
                end
                else
                begin
                    known = 1'b1;
                    decoded = 8'h00;
                    case (ch)
                        8'h22: decoded = 8'h22;
                        8'h5C: decoded = 8'h5C;
                        "/":   decoded = 8'h2F;
                        "b":   decoded = 8'h08;
                        "f":   decoded = 8'h0C;
                        "n":   decoded = 8'h0A;
                        "r":   decoded = 8'h0D;
                        "t":   decoded = 8'h09;
                        default: known = 1'b0;
                    endcase
                    if (known)
                    begin
                        note_token(K_STRING_BYTE, decoded, tok_start, 16'd0);
                        lex_mode = LEX_STR;
                    end
                    else
                        raise_error(p);
                end
            end
            LEX_STR_HEX:
            begin
                bump_length();
                known = 1'b1;
                nibble = 4'h0;
                if (digit_char(ch))
                    nibble = 4'(ch - 8'h30);
                else if (ch >= "A" && ch <= "F")
                    nibble = 4'(ch - 8'h37);
                else
                    known = 1'b0;
                if (!known)
                    raise_error(p);
                else
                begin
                    hex_acc = {hex_acc[11:0], nibble};
                    if (hex_cnt == 2'd3)
                    begin
                        put_utf8(hex_acc);
                        lex_mode = LEX_STR;
                    end
                    else
                        hex_cnt = hex_cnt + 2'd1;
                end
            end
            default:
            begin
                lex_mode = LEX_IDLE;
                lex_between_tokens(ch, p);
            end
        endcase
    endtask

    // Works out the tokens of one accepted word and queues them.
    task automatic predict_tokens(input logic [7:0] ch, input logic em);
        step_tokens.delete();
        if (em)
        begin
            if (!err_latched)
            begin
                if (lex_mode == LEX_KEYWORD_END)
                    close_keyword();
                else if (lex_mode == LEX_INT || lex_mode == LEX_FRAC || lex_mode == LEX_EXP)
                    close_number();
            end
            note_token(K_EOF, 8'h00, text_pos, 16'd0);
            lex_mode = LEX_IDLE;
            kw_sel = 2'd0;
            kw_idx = 3'd0;
            num_is_float = 1'b0;
            hex_acc = 16'h0000;
            hex_cnt = 2'd0;
            text_pos = 32'd0;
            tok_start = 32'd0;
            tok_len_cnt = 16'd0;
            err_latched = 1'b0;
        end
        else
        begin
            if (!err_latched)
                lex_text_byte(ch, text_pos);
            if (text_pos != 32'hFFFF_FFFF)
                text_pos = text_pos + 32'd1;
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endtask

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Predicts on every accepted word and checks every accepted result word.
    always @(posedge clk)
    begin : monitor
        token_rec_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                predict_tokens(text_byte, end_mark);
            if (result_valid && !result_stall)
            begin
                if (pending_tokens.size() == 0)
                begin
                    $error("result word with nothing expected: kind %0d at %0d",
                           kind, start_pos);
                    mismatches++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    mismatches += field_differs("kind", 32'(want.kind), 32'(kind));
                    mismatches += field_differs("content_byte", 32'(want.content),
                                                32'(content_byte));
                    mismatches += field_differs("start_pos", want.pos, start_pos);
                    mismatches += field_differs("token_len", 32'(want.len), 32'(token_len));
                    mismatches += field_differs("last", 32'(want.last), 32'(last));
                end
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Ends the run when nothing has moved for too long.
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("[json_byte_tokenizer_unit] ERROR");
        $finish;
    end

    // Result side: random stall, or a long hold when a test asks for one.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_hold > 0)
            begin
                result_stall <= 1'b1;
                stall_hold--;
            end
            else
                result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Offers one word, with random idle cycles first, and returns once it is taken.
    task automatic send_word(input logic [7:0] ch, input logic em);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        text_byte <= ch;
        end_mark <= em;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_word(8'($urandom_range(255, 0)), 1'b1);
    endtask

    // Stops offering and waits until every predicted token has come back.
    task automatic wait_until_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    // Builds a short random document, mostly well formed.
    task automatic compose_document();
        int         base;
        int         lo;
        logic [7:0] raw;
        logic [15:0] code;
        string      spelling;
        doc_bytes.delete();
        repeat ($urandom_range(3, 1))
        begin
            case ($urandom_range(19, 0))
                0, 1, 2, 3: doc_bytes.push_back(punct_set[$urandom_range(5, 0)]);
                4, 5, 6:
                begin
                    spelling = keyword_spelling[$urandom_range(2, 0)];
                    base = doc_bytes.size();
                    for (int i = 0; i < spelling.len(); i++)
                        doc_bytes.push_back(spelling[i]);
                    // Now and then a letter is misspelt or a letter trails the keyword.
                    if ($urandom_range(7, 0) == 0)
                        doc_bytes[base + $urandom_range(spelling.len() - 1, 1)] =
                            8'($urandom_range(8'h7A, 8'h61));
                    if ($urandom_range(7, 0) == 0)
                        doc_bytes.push_back(8'($urandom_range(8'h5A, 8'h41)));
                end
                7, 8, 9, 10:
                begin
                    // A group that may be empty makes the number malformed.
                    lo = ($urandom_range(9, 0) == 0) ? 0 : 1;
                    if ($urandom_range(1, 0))
                        doc_bytes.push_back(8'h2D);
                    repeat ($urandom_range(4, lo))
                        doc_bytes.push_back(random_digit());
                    if ($urandom_range(1, 0))
                    begin
                        doc_bytes.push_back(8'h2E);
                        repeat ($urandom_range(3, lo))
                            doc_bytes.push_back(random_digit());
                    end
                    if ($urandom_range(2, 0) == 0)
                    begin
                        doc_bytes.push_back($urandom_range(1, 0) ? 8'h65 : 8'h45);
                        case ($urandom_range(2, 0))
                            1: doc_bytes.push_back(8'h2B);
                            2: doc_bytes.push_back(8'h2D);
                            default: ;
                        endcase
                        repeat ($urandom_range(2, lo))
                            doc_bytes.push_back(random_digit());
                    end
                end
                11, 12, 13, 14, 15:
                begin
                    doc_bytes.push_back(8'h22);
                    repeat ($urandom_range(5, 0))
                    begin
                        case ($urandom_range(3, 0))
                            0, 1:
                            begin
                                raw = 8'($urandom_range(255, 0));
                                if (raw == 8'h22 || raw == 8'h5C)
                                    raw = 8'h7E;
                                doc_bytes.push_back(raw);
                            end
                            2:
                            begin
                                // Rarely an escape letter that JSON does not define.
                                doc_bytes.push_back(8'h5C);
                                doc_bytes.push_back(($urandom_range(15, 0) == 0) ? 8'h71 :
                                                    escape_set[$urandom_range(7, 0)]);
                            end
                            default:
                            begin
                                case ($urandom_range(2, 0))
                                    0: code = 16'($urandom_range(16'h007F, 0));
                                    1: code = 16'($urandom_range(16'h07FF, 16'h0080));
                                    default: code = 16'($urandom_range(16'hFFFF, 16'h0800));
                                endcase
                                doc_bytes.push_back(8'h5C);
                                doc_bytes.push_back(8'h75);
                                for (int n = 3; n >= 0; n--)
                                    doc_bytes.push_back(hex_digit(code[n*4 +: 4]));
                                // Occasionally a lowercase or non-hex digit slips in.
                                if ($urandom_range(11, 0) == 0)
                                    doc_bytes[doc_bytes.size() - 1 - $urandom_range(3, 0)] =
                                        8'($urandom_range(8'h67, 8'h61));
                            end
                        endcase
                    end
                    if ($urandom_range(9, 0) != 0)
                        doc_bytes.push_back(8'h22);
                end
                16, 17, 18: doc_bytes.push_back(space_set[$urandom_range(4, 0)]);
                default: doc_bytes.push_back(8'($urandom_range(255, 0)));
            endcase
            if ($urandom_range(3, 0) != 0)
                doc_bytes.push_back(sep_set[$urandom_range(3, 0)]);
        end
    endtask

    // Empty text, punctuation and every whitespace byte.
    task automatic test_punctuation();
        send_word(8'hFF, 1'b1);
        send_text("{ }\t[\n]\013,\015:");
        send_end();
        wait_until_drained();
    endtask

    // Keywords whole, cut short, misspelt and followed by a letter.
    task automatic test_keywords();
        send_text("true,false null");
        send_end();
        send_text("nul");
        send_end();
        send_text("nulL]");
        send_end();
        send_text("falsey");
        send_end();
        wait_until_drained();
    endtask

    // Number forms, several malformed shapes, and numbers closed by the end marker.
    task automatic test_numbers();
        send_text("-0012.50e+7]3E9,-1E-2 0");
        send_end();
        send_text("-x");
        send_end();
        send_text("1.e");
        send_end();
        send_text("2e+,");
        send_end();
        send_text("4.");
        send_end();
        wait_until_drained();
    endtask

    // Escapes, raw control and high bytes, \u values of every size and bad escapes.
    task automatic test_strings();
        send_text("\"a\\\"\\\\\\/\\b\\f\\n\\r\\t\"");
        send_word(8'h22, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h1F, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h22, 1'b0);
        send_text("\"\\u0041\\u00E9\\uD83D\\uFFFF\"");
        send_end();
        send_text("\"\\q\"");
        send_end();
        send_text("\"\\u00e9\"");
        send_end();
        send_text("\"ab");
        send_end();
        wait_until_drained();
    endtask

    // Stray bytes at the extremes; the error holds until the end marker.
    task automatic test_sticky_error();
        send_word(8'h00, 1'b0);
        send_text("{1");
        send_end();
        send_word(8'hFF, 1'b0);
        send_end();
        wait_until_drained();
    endtask

    // The result side holds off while words keep coming, so the input backs up.
    task automatic test_result_backpressure();
        stall_hold = 64;
        send_text("[1,22,\"\\u20AC\",true,{\"k\":null},-3.5]");
        send_end();
        wait_until_drained();
    endtask

    task automatic test_random_documents(input int idle_pct, input int stall_pct,
                                         input int word_goal);
        int sent;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < word_goal)
        begin
            compose_document();
            foreach (doc_bytes[i])
                send_word(doc_bytes[i], 1'b0);
            send_end();
            sent += doc_bytes.size() + 1;
        end
        wait_until_drained();
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_punctuation();
        test_keywords();
        test_numbers();
        test_strings();
        test_sticky_error();
        test_result_backpressure();
        test_random_documents(0, 0, 10);
        test_random_documents(51, 0, 10);
        test_random_documents(0, 51, 10);
        test_random_documents(13, 13, 10);

        // Let any stray result word show itself before the verdict.
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("[json_byte_tokenizer_unit] OK");
        else
            $display("[json_byte_tokenizer_unit] ERROR");
        $finish;
    end

endmodule

/* json_byte_tokenizer_unit.f */
+incdir+src
src/jbt_pkg.sv
src/json_byte_tokenizer_unit.sv
tb/testbench.sv
